/* rtl/core/flb_pkg.sv */
// Package: fault-code blink pattern tables, widths and pattern codes.
package flb_pkg;

  localparam int unsigned PatW   = 4;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CountW = 11;
  localparam int unsigned TDataW = 8;

  localparam logic [PatW-1:0] PatHard    = 4'd0;
  localparam logic [PatW-1:0] PatMemory  = 4'd1;
  localparam logic [PatW-1:0] PatBus     = 4'd2;
  localparam logic [PatW-1:0] PatUsage   = 4'd3;
  localparam logic [PatW-1:0] PatControl = 4'd4;
  localparam logic [PatW-1:0] PatOsc     = 4'd5;
  localparam logic [PatW-1:0] PatClock   = 4'd6;
  localparam logic [PatW-1:0] PatTask    = 4'd7;
  localparam logic [PatW-1:0] PatUart    = 4'd8;
  localparam logic [PatW-1:0] PatQueue   = 4'd9;
  localparam logic [PatW-1:0] PatMalloc  = 4'd10;

  // number of elements in a pattern; unused codes play the hard pattern
  function automatic logic [IdxW-1:0] pat_len(input logic [PatW-1:0] pat);
    logic [IdxW-1:0] len;
    case (pat)
      PatOsc:    len = 3'd5;
      PatClock:  len = 3'd2;
      PatTask:   len = 3'd3;
      PatUart:   len = 3'd4;
      PatQueue:  len = 3'd5;
      PatMalloc: len = 3'd6;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  // phase length in ms for one element of one pattern
  function automatic logic [CountW-1:0] elem_dur(input logic [PatW-1:0] pat,
                                                 input logic [IdxW-1:0] idx,
                                                 input logic            off);
    logic [CountW-1:0] on_ms;
    logic [CountW-1:0] off_ms;
    logic              last;
    last   = ((idx + 3'd1) >= pat_len(pat));
    on_ms  = 11'd20;
    off_ms = 11'd20;
    case (pat)
      PatMemory: begin
        on_ms  = 11'd500;
        off_ms = 11'd500;
      end
      PatBus: begin
        on_ms  = 11'd2000;
        off_ms = 11'd2000;
      end
      PatUsage: begin
        on_ms  = 11'd2000;
        off_ms = 11'd200;
      end
      PatControl: begin
        on_ms  = 11'd200;
        off_ms = 11'd2000;
      end
      PatOsc: begin
        on_ms  = 11'd20;
        off_ms = last ? 11'd2000 : 11'd20;
      end
      PatClock, PatTask, PatUart, PatQueue, PatMalloc: begin
        on_ms  = 11'd500;
        off_ms = last ? 11'd2000 : 11'd500;
      end
      default: begin
        on_ms  = 11'd20;
        off_ms = 11'd20;
      end
    endcase
    return off ? off_ms : on_ms;
  endfunction

endpackage

/* rtl/core/fault_code_led_blinker_top.sv */
// Fault-code LED blinker: per-tick pattern sequencer with registered result.
//
// channel  | dir | beat contents
// s_axis   | in  | tdata[0] tick, tdata[7:1] zero
// m_axis   | out | tdata[0] led_on, tdata[7:1] zero; tlast pattern_end
// cfg      | in  | cfg_wdata_i pattern_select, written when cfg_we_i is high
//
// One beat per cycle unless stalled; the output register takes its result.
// Throughput is set by the single output register; s_axis_tready drops only
// while that register holds a beat that m_axis_tready does not take.
// Reset (rst_ni low, async) selects the hard pattern, first element, on phase.
// A config write restarts the pattern at its first element.
module fault_code_led_blinker_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [flb_pkg::PatW-1:0]   cfg_wdata_i,   // [3:0] pattern_select
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [flb_pkg::TDataW-1:0] s_axis_tdata,  // [0] tick, [7:1] pad
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [flb_pkg::TDataW-1:0] m_axis_tdata,  // [0] led_on, [7:1] pad
  output logic                       m_axis_tlast   // pattern_end
);

  logic [flb_pkg::PatW-1:0]   pat_q;
  logic [flb_pkg::IdxW-1:0]   idx_q,   idx_d;
  logic                       off_q,   off_d;
  logic [flb_pkg::CountW-1:0] cnt_q,   cnt_d;
  logic                       ovld_q;
  logic                       led_q,   led_d;
  logic                       end_q,   end_d;

  logic [flb_pkg::IdxW-1:0]   len;
  logic [flb_pkg::IdxW-1:0]   idx_eff;
  logic [flb_pkg::CountW-1:0] dur;
  logic [flb_pkg::CountW-1:0] cnt_inc;
  logic                       beat;
  logic                       tick;

  assign s_axis_tready = !ovld_q || m_axis_tready;
  assign beat          = s_axis_tvalid && s_axis_tready;
  assign tick          = s_axis_tdata[0];

  assign len     = flb_pkg::pat_len(pat_q);
  assign idx_eff = (idx_q >= len) ? '0 : idx_q;
  assign dur     = flb_pkg::elem_dur(pat_q, idx_eff, off_q);
  assign cnt_inc = cnt_q + 11'd1;

  always_comb begin
    idx_d = idx_eff;
    off_d = off_q;
    cnt_d = cnt_q;
    end_d = 1'b0;
    led_d = !off_q;
    if (tick) begin
      cnt_d = cnt_inc;
      if (cnt_inc >= dur) begin
        cnt_d = '0;
        if (!off_q) begin
          off_d = 1'b1;
        end else begin
          off_d = 1'b0;
          if ((idx_eff + 3'd1) >= len) begin
            idx_d = '0;
            end_d = 1'b1;
          end else begin
            idx_d = idx_eff + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= flb_pkg::PatHard;
      idx_q <= '0;
      off_q <= 1'b0;
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      pat_q <= cfg_wdata_i;
      idx_q <= '0;
      off_q <= 1'b0;
      cnt_q <= '0;
    end else if (beat) begin
      idx_q <= idx_d;
      off_q <= off_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (beat) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      led_q <= led_d;
      end_q <= end_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {{(flb_pkg::TDataW-1){1'b0}}, led_q};
  assign m_axis_tlast  = end_q;

  // a pass ends only at the close of an off phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[0])
    else $error("pattern_end with LED lit");

  // counter stays inside the current phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < dur)
    else $error("ms counter past phase length");

  // element index stays inside the pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < len)
    else $error("element index past pattern length");

  // config write restarts the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (cnt_q == '0) && (idx_q == '0) && !off_q)
    else $error("config write did not restart");

  // held result while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(end_q) && $stable(led_q))
    else $error("stalled result changed");

endmodule
